// ===== hw/rtl/priority_lock_queue_macros.svh =====
// Assertion macros for the priority lock queue.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef PRIORITY_LOCK_QUEUE_MACROS_SVH
`define PRIORITY_LOCK_QUEUE_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define PLQ_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define PLQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define PLQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/plq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plq_pkg
// Shared types and constants of the priority lock queue.
// ----------------------------------------------------------------------------
package plq_pkg;

    // Width of the waiter count reported on the result channel
    localparam int WAIT_W = 5;

    typedef enum logic [1:0] {
        ST_GRANTED      = 2'd0,
        ST_QUEUED       = 2'd1,
        ST_FULL         = 2'd2,
        ST_FREE_RELEASE = 2'd3
    } plq_status_t;

    typedef enum logic {
        ACT_ENTER   = 1'b0,
        ACT_RELEASE = 1'b1
    } plq_action_t;

    // Per-cycle command broadcast along the cell row
    typedef struct packed {
        logic insert;
        logic pop;
    } plq_cell_ctl_t;

endpackage

// ===== hw/rtl/plq_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plq_req_if
// Request channel: enter and release events with valid/ready handshake.
// ----------------------------------------------------------------------------
interface plq_req_if #(
    parameter int ID_WIDTH       = 8,
    parameter int PRIORITY_WIDTH = 8
);
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [ID_WIDTH-1:0]       requester;
    logic [PRIORITY_WIDTH-1:0] priority_req;

    modport source (output valid, output action, output requester, output priority_req,
                    input ready);
    modport sink   (input valid, input action, input requester, input priority_req,
                    output ready);
endinterface

// ===== hw/rtl/plq_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plq_rsp_if
// Result channel: one result per accepted request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface plq_rsp_if #(
    parameter int ID_WIDTH = 8
);
    logic                      valid;
    logic                      ready;
    logic                      grant_valid;
    logic [ID_WIDTH-1:0]       grant_to;
    plq_pkg::plq_status_t      status;
    logic                      lock_busy;
    logic [plq_pkg::WAIT_W-1:0] waiting;

    modport source (output valid, output grant_valid, output grant_to, output status,
                    output lock_busy, output waiting, input ready);
    modport sink   (input valid, input grant_valid, input grant_to, input status,
                    input lock_busy, input waiting, output ready);
endinterface

// ===== hw/rtl/plq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plq_cell
// One slot of the sorted waiter row: compares, holds, or shifts by one place.
// ----------------------------------------------------------------------------
module plq_cell #(
    parameter int ID_WIDTH       = 8,
    parameter int PRIORITY_WIDTH = 8
) (
    input  logic                      clk,
    input  plq_pkg::plq_cell_ctl_t    ctl,
    input  logic                      occ,
    input  logic [PRIORITY_WIDTH-1:0] new_prio,
    input  logic [ID_WIDTH-1:0]       new_owner,
    input  logic                      left_stay,
    input  logic [PRIORITY_WIDTH-1:0] left_prio,
    input  logic [ID_WIDTH-1:0]       left_owner,
    input  logic [PRIORITY_WIDTH-1:0] right_prio,
    input  logic [ID_WIDTH-1:0]       right_owner,
    output logic                      stay,
    output logic [PRIORITY_WIDTH-1:0] prio,
    output logic [ID_WIDTH-1:0]       owner
);

    logic [PRIORITY_WIDTH-1:0] prio_reg;
    logic [PRIORITY_WIDTH-1:0] prio_next;
    logic [ID_WIDTH-1:0]       owner_reg;
    logic [ID_WIDTH-1:0]       owner_next;

    // Strictly greater keeps its place: a newcomer goes ahead of equal priority
    assign stay  = occ && (prio_reg > new_prio);
    assign prio  = prio_reg;
    assign owner = owner_reg;

    always_comb
    begin
        prio_next  = prio_reg;
        owner_next = owner_reg;
        if (ctl.insert)
        begin
            if (!stay)
            begin
                if (left_stay)
                begin
                    prio_next  = new_prio;
                    owner_next = new_owner;
                end
                else
                begin
                    prio_next  = left_prio;
                    owner_next = left_owner;
                end
            end
        end
        else if (ctl.pop)
        begin
            prio_next  = right_prio;
            owner_next = right_owner;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg  <= prio_next;
        owner_reg <= owner_next;
    end

endmodule

// ===== hw/rtl/priority_lock_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_lock_queue
// Priority-ordered lock manager built on a row of sorting cells.
// ----------------------------------------------------------------------------
// Usage:
//   req carries enter (action 0, requester, priority_req) and release
//   (action 1) transactions; rsp returns exactly one result per request:
//   grant_valid/grant_to, status, lock_busy and the waiter count after it.
//   Each request is resolved in the cycle it is accepted: the row of
//   QUEUE_DEPTH cells compares the new priority in parallel and all cells
//   shift together, so one transaction per cycle is taken while req.ready
//   is high, and its result appears on rsp in the cycle after acceptance.
//   The result sits in an output register; req.ready stays high while that
//   register is empty or being drained, so a stalled receiver holds rsp
//   steady and back-pressures req only when a result is still waiting.
//   Reset frees the lock and empties the queue at once; no clearing pass is
//   needed since cells beyond the waiter count are never read.
// ----------------------------------------------------------------------------
`include "priority_lock_queue_macros.svh"

module priority_lock_queue #(
    parameter int QUEUE_DEPTH    = 16,
    parameter int PRIORITY_WIDTH = 8,
    parameter int ID_WIDTH       = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    plq_req_if.sink   req,
    plq_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic                       busy_reg;
    logic                       busy_next;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;

    logic                       rsp_valid_reg;
    logic                       grant_valid_reg;
    logic                       grant_valid_next;
    logic [ID_WIDTH-1:0]        grant_to_reg;
    logic [ID_WIDTH-1:0]        grant_to_next;
    plq_pkg::plq_status_t       status_reg;
    plq_pkg::plq_status_t       status_next;
    logic [plq_pkg::WAIT_W-1:0] waiting_reg;

    logic                       accept;
    logic                       full;
    plq_pkg::plq_cell_ctl_t     ctl;

    logic [QUEUE_DEPTH-1:0]     occ;
    logic [QUEUE_DEPTH-1:0]     cell_stay;
    logic [PRIORITY_WIDTH-1:0]  cell_prio  [QUEUE_DEPTH];
    logic [ID_WIDTH-1:0]        cell_owner [QUEUE_DEPTH];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));

    // ---- cell row ----
    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            logic                      l_stay;
            logic [PRIORITY_WIDTH-1:0] l_prio;
            logic [ID_WIDTH-1:0]       l_owner;
            logic [PRIORITY_WIDTH-1:0] r_prio;
            logic [ID_WIDTH-1:0]       r_owner;

            assign occ[i] = (count_reg > CNT_W'(i));

            if (i == 0)
            begin : g_head
                // head always takes the newcomer when it does not stay
                assign l_stay  = 1'b1;
                assign l_prio  = req.priority_req;
                assign l_owner = req.requester;
            end
            else
            begin : g_body
                assign l_stay  = cell_stay[i-1];
                assign l_prio  = cell_prio[i-1];
                assign l_owner = cell_owner[i-1];
            end

            if (i == QUEUE_DEPTH - 1)
            begin : g_tail
                assign r_prio  = cell_prio[i];
                assign r_owner = cell_owner[i];
            end
            else
            begin : g_mid
                assign r_prio  = cell_prio[i+1];
                assign r_owner = cell_owner[i+1];
            end

            plq_cell #(
                .ID_WIDTH       (ID_WIDTH),
                .PRIORITY_WIDTH (PRIORITY_WIDTH)
            ) u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .occ         (occ[i]),
                .new_prio    (req.priority_req),
                .new_owner   (req.requester),
                .left_stay   (l_stay),
                .left_prio   (l_prio),
                .left_owner  (l_owner),
                .right_prio  (r_prio),
                .right_owner (r_owner),
                .stay        (cell_stay[i]),
                .prio        (cell_prio[i]),
                .owner       (cell_owner[i])
            );
        end
    endgenerate

    // ---- lock control ----
    always_comb
    begin
        busy_next        = busy_reg;
        count_next       = count_reg;
        grant_valid_next = 1'b0;
        grant_to_next    = '0;
        status_next      = plq_pkg::ST_GRANTED;
        ctl              = '0;
        case (plq_pkg::plq_action_t'(req.action))
            plq_pkg::ACT_ENTER:
            begin
                if (!busy_reg)
                begin
                    busy_next        = 1'b1;
                    grant_valid_next = 1'b1;
                    grant_to_next    = req.requester;
                end
                else if (full)
                begin
                    status_next = plq_pkg::ST_FULL;
                end
                else
                begin
                    ctl.insert  = accept;
                    count_next  = count_reg + CNT_W'(1);
                    status_next = plq_pkg::ST_QUEUED;
                end
            end
            plq_pkg::ACT_RELEASE:
            begin
                if (!busy_reg)
                begin
                    status_next = plq_pkg::ST_FREE_RELEASE;
                end
                else if (count_reg != '0)
                begin
                    // atomic handoff to the head waiter
                    ctl.pop          = accept;
                    count_next       = count_reg - CNT_W'(1);
                    grant_valid_next = 1'b1;
                    grant_to_next    = cell_owner[0];
                end
                else
                begin
                    busy_next = 1'b0;
                end
            end
            default:
            begin
                status_next = plq_pkg::ST_GRANTED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg      <= busy_next;
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            grant_valid_reg <= grant_valid_next;
            grant_to_reg    <= grant_to_next;
            status_reg      <= status_next;
            waiting_reg     <= plq_pkg::WAIT_W'(count_next);
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.grant_valid = grant_valid_reg;
    assign rsp.grant_to    = grant_to_reg;
    assign rsp.status      = status_reg;
    assign rsp.lock_busy   = busy_reg;
    assign rsp.waiting     = waiting_reg;

    // ---- checks ----
    `PLQ_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(QUEUE_DEPTH),
        "waiter count beyond queue depth")

    `PLQ_ASSERT_SAME(a_waiters_need_owner, count_reg != '0, busy_reg,
        "waiters present while lock is free")

    `PLQ_ASSERT_NEXT(a_free_release_noop,
        accept && req.action == plq_pkg::ACT_RELEASE && !busy_reg,
        !busy_reg && count_reg == $past(count_reg) &&
            status_reg == plq_pkg::ST_FREE_RELEASE,
        "release of a free lock changed state")

    `PLQ_ASSERT_NEXT(a_enter_free_grants,
        accept && req.action == plq_pkg::ACT_ENTER && !busy_reg,
        rsp_valid_reg && busy_reg && grant_valid_reg && grant_to_reg == $past(req.requester),
        "enter on a free lock not granted")

    `PLQ_ASSERT_NEXT(a_handoff_head,
        accept && req.action == plq_pkg::ACT_RELEASE && busy_reg && count_reg != '0,
        busy_reg && grant_to_reg == $past(cell_owner[0]) &&
            count_reg == $past(count_reg) - CNT_W'(1),
        "release with waiters did not hand over to the head")

endmodule
